// ----- rtl/sbfr_pkg.sv -----
// constants and types for the seven-bit frame receiver
package sbfr_pkg;

  localparam int unsigned MAX_CONT_BYTES = 10;
  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned STORE_DEPTH    = MAX_DATA_BYTES + 1;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DATA_W  = BYTE_W * MAX_DATA_BYTES;
  localparam int unsigned CONT_W  = 4;
  localparam int unsigned FILL_W  = 3;
  localparam int unsigned ACCUM_W = 7;
  localparam int unsigned HDR_W   = 5;

  localparam logic [KIND_W-1:0] KIND_READ_RESPONSE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ_REQUEST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE_REQUEST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXEC_REQUEST  = 2'd3;

  localparam logic [FILL_W-1:0] HEADER_FILL = 3'd2;

endpackage

// ----- rtl/seven_bit_frame_receiver.sv -----
// seven-bit frame receiver: header/continuation byte unpacking into frame results
//
//   channel  signals                                          direction
//   rx       rx_valid, rx_stall, rx_byte                      byte in
//   frame    frame_valid, frame_stall, frame_kind, var_index,  result out
//            data_len, data_bytes
//
// one received byte per cycle while rx_stall is low; each byte is unpacked combinationally into
// the frame state and, on the byte that completes a frame, into the result register.
// the result is registered when the completing byte is accepted.
// rst clears the frame state and the result valid flag; the payload store is not reset.
// rx_stall rises only when a frame-completing byte meets a result still held by frame_stall.
module seven_bit_frame_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rx_valid,
  output logic                               rx_stall,
  input  logic [sbfr_pkg::BYTE_W-1:0]        rx_byte,
  output logic                               frame_valid,
  input  logic                               frame_stall,
  output logic [sbfr_pkg::KIND_W-1:0]        frame_kind,
  output logic [sbfr_pkg::BYTE_W-1:0]        var_index,
  output logic [sbfr_pkg::LEN_W-1:0]         data_len,
  output logic [sbfr_pkg::DATA_W-1:0]        data_bytes
);
  import sbfr_pkg::*;

  logic                in_frame;
  logic [CONT_W-1:0]   cont_count;
  logic [HDR_W-1:0]    header_fields;
  logic [ACCUM_W-1:0]  bit_accum;
  logic [FILL_W-1:0]   bit_fill;
  logic [BYTE_W-1:0]   payload_store [STORE_DEPTH];

  logic                accept;
  logic                is_header;
  logic                is_cont;
  logic [CONT_W:0]     k;
  logic                overrun;
  logic                step;
  logic [13:0]         combined;
  logic [LEN_W-1:0]    new_fill;
  logic                extract;
  logic [FILL_W-1:0]   rem;
  logic [ACCUM_W-1:0]  rem_mask;
  logic [BYTE_W-1:0]   new_byte;
  logic [ACCUM_W-1:0]  accum_next;
  logic [FILL_W-1:0]   fill_next;
  logic [6:0]          bit_total;
  logic [LEN_W-1:0]    done;
  logic [LEN_W-1:0]    wr_idx;
  logic [KIND_W-1:0]   kind;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    need;
  logic                emit;
  logic [BYTE_W-1:0]   view [STORE_DEPTH];
  logic [DATA_W-1:0]   data_next;

  assign accept    = rx_valid && !rx_stall;
  assign is_header = rx_byte[7];
  assign is_cont   = !is_header && in_frame;
  assign k         = {1'b0, cont_count} + 5'd1;
  assign overrun   = k > 5'(MAX_CONT_BYTES);
  assign step      = is_cont && !overrun;

  // bit unpacking
  assign combined  = {bit_accum, rx_byte[6:0]};
  assign new_fill  = {1'b0, bit_fill} + 4'd7;
  assign extract   = new_fill >= 4'd8;
  assign rem       = extract ? 3'(new_fill - 4'd8) : 3'd0;
  assign rem_mask  = 7'((8'd1 << rem) - 8'd1);
  assign new_byte  = 8'(combined >> rem);
  assign accum_next = extract ? (combined[6:0] & rem_mask) : combined[6:0];
  assign fill_next  = extract ? rem : 3'(new_fill);

  // completed payload bytes so far
  assign bit_total = 7'd2 + 7'(k) * 7'd7;
  assign done      = bit_total[6:3];
  assign wr_idx    = done - 4'd1;

  always_comb begin
    kind = header_fields[4:3];
    len  = {1'b0, header_fields[2:0]} + 4'd1;
    if (len > LEN_W'(MAX_DATA_BYTES)) begin
      len = LEN_W'(MAX_DATA_BYTES);
    end
    need = (kind == KIND_READ_REQUEST) ? 4'd1 : 4'd1 + len;
  end

  assign emit     = step && (done >= need);
  assign rx_stall = frame_valid && frame_stall && emit;

  // store contents including the byte finished this cycle
  always_comb begin
    for (int e = 0; e < STORE_DEPTH; e++) begin
      if (extract && wr_idx == LEN_W'(e)) begin
        view[e] = new_byte;
      end else begin
        view[e] = payload_store[e];
      end
    end
  end

  always_comb begin
    data_next = '0;
    if (kind != KIND_READ_REQUEST) begin
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
        if (LEN_W'(i) < len) begin
          data_next[BYTE_W*i +: BYTE_W] = view[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      cont_count    <= '0;
      header_fields <= '0;
      bit_accum     <= '0;
      bit_fill      <= '0;
    end else if (accept) begin
      if (is_header) begin
        in_frame      <= 1'b1;
        cont_count    <= '0;
        header_fields <= rx_byte[6:2];
        bit_accum     <= ACCUM_W'(rx_byte[1:0]);
        bit_fill      <= HEADER_FILL;
      end else if (is_cont) begin
        if (overrun || emit) begin
          in_frame   <= 1'b0;
          cont_count <= '0;
          bit_accum  <= '0;
          bit_fill   <= '0;
        end else begin
          cont_count <= k[CONT_W-1:0];
          bit_accum  <= accum_next;
          bit_fill   <= fill_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step && extract && wr_idx < LEN_W'(STORE_DEPTH)) begin
      payload_store[wr_idx] <= new_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept && emit) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frame_kind <= kind;
      var_index  <= view[0];
      data_len   <= len;
      data_bytes <= data_next;
    end
  end

endmodule

// ----- sim/seven_bit_frame_receiver_test.sv -----
// self-checking testbench for the seven-bit frame receiver
`timescale 1ns / 100ps

module seven_bit_frame_receiver_test;
  import sbfr_pkg::*;

  localparam int WHOLE_FRAME    = 16;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 1250;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] var_idx;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] bytes;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic frame_valid;
  logic frame_stall = 1'b0;
  logic [KIND_W-1:0] frame_kind;
  logic [BYTE_W-1:0] var_index;
  logic [LEN_W-1:0] data_len;
  logic [DATA_W-1:0] data_bytes;

  frame_t pending_frames[$];
  frame_t got_frame;
  int mismatches = 0;
  int quiet_cycles = 0;
  int frame_bytes_sent = 0;
  bit no_gaps = 1'b0;
  bit long_hold_req = 1'b0;

  logic pred_in_frame = 1'b0;
  logic [CONT_W-1:0] pred_cont = '0;
  logic [HDR_W-1:0] pred_hdr = '0;
  logic [14:0] pred_accum = '0;
  logic [3:0] pred_fill = '0;
  logic [BYTE_W-1:0] pred_store [STORE_DEPTH];

  seven_bit_frame_receiver uut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame_kind(frame_kind),
    .var_index(var_index),
    .data_len(data_len),
    .data_bytes(data_bytes)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void drop_pred_frame();
    pred_in_frame = 1'b0;
    pred_cont = '0;
    pred_accum = '0;
    pred_fill = '0;
  endfunction

  function automatic void unpack_rx_byte(input logic [BYTE_W-1:0] b);
    logic [CONT_W:0] k;
    logic [3:0] done;
    logic [BYTE_W-1:0] nb;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] need;
    frame_t f;
    if (b[7]) begin
      pred_in_frame = 1'b1;
      pred_cont = '0;
      pred_hdr = b[6:2];
      pred_accum = {13'd0, b[1:0]};
      pred_fill = 4'd2;
      return;
    end
    if (!pred_in_frame) return;
    k = pred_cont + 1'b1;
    if (k > MAX_CONT_BYTES) begin
      drop_pred_frame();
      return;
    end
    pred_cont = k[CONT_W-1:0];
    pred_accum = {pred_accum[7:0], b[6:0]};
    pred_fill = pred_fill + 4'd7;
    done = 4'((2 + 7 * k) / 8);
    if (pred_fill >= 4'd8) begin
      nb = 8'(pred_accum >> (pred_fill - 4'd8));
      pred_fill = pred_fill - 4'd8;
      pred_accum = pred_accum & ((15'd1 << pred_fill) - 15'd1);
      if (done >= 1 && done - 1 < STORE_DEPTH) pred_store[done - 1] = nb;
    end
    kind = pred_hdr[4:3];
    len = {1'b0, pred_hdr[2:0]} + 1'b1;
    if (len > MAX_DATA_BYTES) len = LEN_W'(MAX_DATA_BYTES);
    need = (kind == KIND_READ_REQUEST) ? LEN_W'(1) : len + 1'b1;
    if (done < need) return;
    f.kind = kind;
    f.var_idx = pred_store[0];
    f.len = len;
    f.bytes = '0;
    if (kind != KIND_READ_REQUEST) begin
      for (int i = 0; i < len; i++) f.bytes[8*i +: 8] = pred_store[i + 1];
    end
    pending_frames.push_back(f);
    drop_pred_frame();
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int gap;
    logic stalled;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= value;
    // stall sampled ahead of the edge it applies to
    do begin
      @(negedge clk);
      stalled = rx_stall;
      @(posedge clk);
    end while (stalled !== 1'b0);
    unpack_rx_byte(value);
  endtask

  // header plus up to keep continuation bytes; unused tail bits are random
  task automatic send_frame(input logic [KIND_W-1:0] kind, input logic [2:0] cnt,
                            input logic [BYTE_W-1:0] idx, input logic [DATA_W-1:0] data,
                            input int keep);
    logic [78:0] bits;
    int nbytes;
    int ncont;
    bits = 79'({$urandom(), $urandom(), $urandom()});
    nbytes = (kind == KIND_READ_REQUEST) ? 1 : int'(cnt) + 2;
    ncont = (8 * nbytes + 4) / 7;
    bits[78:71] = idx;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      if (i + 1 < nbytes) bits[70 - 8*i -: 8] = data[8*i +: 8];
    end
    send_byte({1'b1, kind, cnt, bits[78:77]});
    frame_bytes_sent++;
    for (int j = 0; j < ncont && j < keep; j++) begin
      send_byte({1'b0, bits[76 - 7*j -: 7]});
      frame_bytes_sent++;
    end
  endtask

  task automatic send_random_frame(input int keep);
    send_frame(KIND_W'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
               BYTE_W'($urandom()), {$urandom(), $urandom()}, keep);
  endtask

  task automatic test_frame_kinds();
    send_frame(KIND_READ_RESPONSE, 3'd0, 8'h00, '0, WHOLE_FRAME);
    send_frame(KIND_READ_REQUEST, 3'd7, 8'hFF, '1, WHOLE_FRAME);
    send_frame(KIND_WRITE_REQUEST, 3'd0, 8'hA5, 64'h5A, WHOLE_FRAME);
  endtask

  task automatic test_longest_frame();
    send_frame(KIND_EXEC_REQUEST, 3'd7, 8'hFF, '1, WHOLE_FRAME);
    // trailing continuation byte after completion is ignored
    send_byte(8'h7F);
  endtask

  task automatic test_idle_and_restart();
    send_byte(8'h00);
    send_byte(8'h7F);
    // truncated frame dropped by the next header
    send_frame(KIND_WRITE_REQUEST, 3'd3, 8'h3C, 64'h0123_4567_89AB_CDEF, 1);
    send_frame(KIND_READ_REQUEST, 3'd0, 8'h81, '0, WHOLE_FRAME);
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    long_hold_req = 1'b1;
    repeat (8) send_random_frame(WHOLE_FRAME);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int choice;
    int next_toggle;
    start = frame_bytes_sent;
    next_toggle = start + 100;
    while (frame_bytes_sent - start < RANDOM_BYTES) begin
      if (frame_bytes_sent >= next_toggle) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        next_toggle = frame_bytes_sent + 100;
      end
      choice = $urandom_range(0, 9);
      if (choice < 7) send_random_frame(WHOLE_FRAME);
      else if (choice == 7) send_random_frame($urandom_range(0, 9));
      else if (choice == 8) send_byte(BYTE_W'($urandom_range(0, 255)));
      else send_byte(BYTE_W'($urandom_range(0, 127)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin : frame_sink
    int wait_cycles;
    bit taken;
    wait (rst === 1'b0);
    forever begin
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 12);
      if (long_hold_req) begin
        wait_cycles = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        frame_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      frame_stall <= 1'b0;
      do begin
        @(negedge clk);
        taken = (frame_valid === 1'b1 && frame_stall === 1'b0);
        @(posedge clk);
      end while (!taken);
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_valid === 1'b1 && frame_stall === 1'b0) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: kind %0d index %0h len %0d data %h",
               frame_kind, var_index, data_len, data_bytes);
        mismatches++;
      end else begin
        got_frame = pending_frames.pop_front();
        if (frame_kind !== got_frame.kind) begin
          $error("frame_kind: expected %0d, actual %0d", got_frame.kind, frame_kind);
          mismatches++;
        end
        if (var_index !== got_frame.var_idx) begin
          $error("var_index: expected %0h, actual %0h", got_frame.var_idx, var_index);
          mismatches++;
        end
        if (data_len !== got_frame.len) begin
          $error("data_len: expected %0d, actual %0d", got_frame.len, data_len);
          mismatches++;
        end
        if (data_bytes !== got_frame.bytes) begin
          $error("data_bytes: expected %h, actual %h", got_frame.bytes, data_bytes);
          mismatches++;
        end
      end
    end
  end

  // cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_stall === 1'b0) ||
        (frame_valid === 1'b1 && frame_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_frame_kinds();
    test_longest_frame();
    test_idle_and_restart();
    test_backpressure();
    test_random_traffic();
    rx_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
